>>> rtl/dlgc_pkg.sv
`default_nettype none
package dlgc_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned PULSE_W   = 11;

    localparam logic [CFG_IDX_W-1:0] REG_TRACK      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIFT_SCALE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRIP_ZERO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRIP_SCALE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GRIP_MIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GRIP_MAX   = 3'd5;

    localparam logic [1:0] DS_IDLE    = 2'd0;
    localparam logic [1:0] DS_DRIVING = 2'd1;
    localparam logic [1:0] DS_BRAKED  = 2'd2;

    localparam logic [1:0] GR_MIN   = 2'd0;
    localparam logic [1:0] GR_MAX   = 2'd1;
    localparam logic [1:0] GR_ANGLE = 2'd2;
    localparam logic [1:0] GR_KEEP  = 2'd3;

    localparam logic [PULSE_W-1:0] PULSE_NEUTRAL = 11'd1500;

    // divider: 48-bit dividend magnitude, 16-bit divisor
    localparam int unsigned DIV_N   = 48;
    localparam int unsigned DIV_CNT = 6;

    typedef struct packed {
        logic load_in;    // capture item, compute target and drive
        logic start_lift; // launch lift division
        logic start_grip; // launch grip division
        logic take_lift;  // store lift quotient
        logic take_grip;  // store grip quotient
        logic finish;     // build result
    } dlgc_cmd_t;

    typedef struct packed {
        logic div_done;
    } dlgc_sts_t;

    function automatic logic signed [17:0] sat_err(input logic signed [39:0] v);
        if (v > 40'sd300) begin
            sat_err = 18'sd300;
        end else if (v < -40'sd300) begin
            sat_err = -18'sd300;
        end else begin
            sat_err = v[17:0];
        end
    endfunction

    function automatic logic [PULSE_W-1:0] loop_pulse(input logic signed [17:0] u);
        logic signed [17:0] p;
        p = 18'sd1500 + u;
        loop_pulse = p[PULSE_W-1:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [48:0] v);
        if (v > 49'sd32767) begin
            sat16 = 16'sh7fff;
        end else if (v < -49'sd32768) begin
            sat16 = 16'sh8000;
        end else begin
            sat16 = v[15:0];
        end
    endfunction

endpackage
`default_nettype wire

>>> rtl/drive_lift_grip_control_tick_top.sv
// Each item runs through two 48-step divisions in turn, lift then grip, on one shared
// iterative divider; a new item is taken only after the last result is built.
// A finished result waits in the output register while the next item is taken.
// Reset: aresetn synchronous active low; config registers return to their reset values,
// grip target clears to zero, no result pending.
`default_nettype none
module drive_lift_grip_control_tick_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [15:0]  cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // forward_speed, turn_rate, hold_time_ms, ms_since_command, lift_target_mm,
    // lift_speed, grip_angle_arg, lift_count, grip_count
    input  wire logic [191:0] s_tdata,
    // brake_active, lift_velocity_mode, grip_request
    input  wire logic [3:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // left_pulse_us, right_pulse_us, lift_pulse_us, grip_pulse_us, drive_state,
    // lift_scale_error, grip_scale_error
    output logic [47:0]       m_tdata
);

    logic [15:0] track_reg, lscale_reg, gzero_reg, gscale_reg, gmin_reg, gmax_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            track_reg  <= 16'd600;
            lscale_reg <= 16'd5;
            gzero_reg  <= 16'd0;
            gscale_reg <= 16'd4096;
            gmin_reg   <= 16'd0;
            gmax_reg   <= 16'd90;
        end else if (cfg_we) begin
            unique case (cfg_index)
                dlgc_pkg::REG_TRACK:      track_reg  <= cfg_data;
                dlgc_pkg::REG_LIFT_SCALE: lscale_reg <= cfg_data;
                dlgc_pkg::REG_GRIP_ZERO:  gzero_reg  <= cfg_data;
                dlgc_pkg::REG_GRIP_SCALE: gscale_reg <= cfg_data;
                dlgc_pkg::REG_GRIP_MIN:   gmin_reg   <= cfg_data;
                dlgc_pkg::REG_GRIP_MAX:   gmax_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    dlgc_pkg::dlgc_cmd_t cmd;
    dlgc_pkg::dlgc_sts_t sts;

    dlgc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dlgc_datapath u_dp (
        .aclk                    (aclk),
        .aresetn                 (aresetn),
        .cmd                     (cmd),
        .sts                     (sts),
        .track_width_mm          (track_reg),
        .lift_counts_per_mm      (lscale_reg),
        .grip_zero_count         (gzero_reg),
        .grip_counts_per_deg_q12 (gscale_reg),
        .grip_min_deg            (gmin_reg),
        .grip_max_deg            (gmax_reg),
        .in_data                 ({s_tuser, s_tdata}),
        .out_data                (m_tdata)
    );

endmodule
`default_nettype wire

>>> rtl/dlgc_div.sv
`default_nettype none
module dlgc_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [dlgc_pkg::DIV_N-1:0]    dividend,
    input  wire logic [15:0]                   divisor,
    output logic                               done,
    output logic [dlgc_pkg::DIV_N-1:0]         quotient
);

    logic [dlgc_pkg::DIV_N-1:0]   quot_reg, quot_next;
    logic [15:0]                  rem_reg, rem_next;
    logic [15:0]                  dsr_reg;
    logic [dlgc_pkg::DIV_CNT-1:0] cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [16:0]                  trial;
    logic [17:0]                  diff;

    always_comb begin
        trial     = {rem_reg, quot_reg[dlgc_pkg::DIV_N-1]};
        diff      = {1'b0, trial} - {2'b0, dsr_reg};
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quot_next = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (diff[17]) begin
                rem_next = trial[15:0];
                quot_next = {quot_reg[dlgc_pkg::DIV_N-2:0], 1'b0};
            end else begin
                rem_next = diff[15:0];
                quot_next = {quot_reg[dlgc_pkg::DIV_N-2:0], 1'b1};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == dlgc_pkg::DIV_CNT'(dlgc_pkg::DIV_N - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        if (start) begin
            dsr_reg <= divisor;
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule
`default_nettype wire

>>> rtl/dlgc_datapath.sv
`default_nettype none
module dlgc_datapath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire dlgc_pkg::dlgc_cmd_t cmd,
    output dlgc_pkg::dlgc_sts_t      sts,
    input  wire logic [15:0]         track_width_mm,
    input  wire logic [15:0]         lift_counts_per_mm,
    input  wire logic [15:0]         grip_zero_count,
    input  wire logic [15:0]         grip_counts_per_deg_q12,
    input  wire logic [15:0]         grip_min_deg,
    input  wire logic [15:0]         grip_max_deg,
    input  wire logic [195:0]        in_data,
    output logic [47:0]              out_data
);

    logic signed [15:0] vx, w, lift_target, lift_speed, arg;
    logic [15:0]        hold;
    logic [31:0]        since;
    logic               brake, vel_mode;
    logic [1:0]         req;
    logic signed [31:0] lcount, gcount;

    logic signed [15:0] lift_target_reg, lift_speed_reg;
    logic               vel_mode_reg;
    logic signed [31:0] lcount_reg;
    logic signed [32:0] gdelta_reg;
    logic signed [15:0] gtarget_reg;
    logic signed [15:0] vx_reg, w_reg;
    logic signed [33:0] prod_reg;
    logic signed [34:0] rot_reg;
    logic [10:0]        left_reg, right_reg;
    logic [1:0]         dstate_reg;
    logic signed [15:0] lift_h_reg, grip_deg_reg;
    logic [47:0]        out_reg;

    logic               div_start, div_done;
    logic [47:0]        div_dividend, div_quot;
    logic [15:0]        div_divisor;

    assign vx          = in_data[15:0];
    assign w           = in_data[31:16];
    assign hold        = in_data[47:32];
    assign since       = in_data[79:48];
    assign lift_target = in_data[95:80];
    assign lift_speed  = in_data[111:96];
    assign arg         = in_data[127:112];
    assign lcount      = in_data[159:128];
    assign gcount      = in_data[191:160];
    assign brake       = in_data[192];
    assign vel_mode    = in_data[193];
    assign req         = in_data[195:194];

    // drive mixing: rot = w*track/2000 by reciprocal multiply on magnitude
    logic [15:0]        track;
    logic [33:0]        prod_mag;
    logic [67:0]        recip;
    logic [33:0]        q0;
    logic signed [34:0] rot, lsum, rsum;
    logic signed [10:0] lsat, rsat;
    logic [15:0]        hold_eff;
    logic signed [15:0] gmin, gmax, tgt_next;

    function automatic logic signed [10:0] clamp500(input logic signed [34:0] v);
        if (v > 35'sd500) begin
            clamp500 = 11'sd500;
        end else if (v < -35'sd500) begin
            clamp500 = -11'sd500;
        end else begin
            clamp500 = v[10:0];
        end
    endfunction

    function automatic logic [10:0] spd_pulse(input logic signed [10:0] s);
        logic signed [20:0] m;
        logic signed [20:0] d;
        m = 21'(s) * 21'sd3;
        d = m / 21'sd4;
        spd_pulse = 11'(21'sd1500 + d);
    endfunction

    always_comb begin
        track    = (track_width_mm == '0) ? 16'd600 : track_width_mm;
        prod_mag = prod_reg[33] ? 34'(-prod_reg) : prod_reg;
        // floor(x/2000) with x < 2^31: x*2^42/2000 reciprocal, exact in this range
        recip    = 68'(prod_mag) * 68'd2199023256;
        q0       = 34'(recip[67:42]);
        rot      = prod_reg[33] ? -$signed({1'b0, q0}) : $signed({1'b0, q0});
        lsum     = 35'(vx_reg) - rot_reg;
        rsum     = 35'(vx_reg) + rot_reg;
        lsat     = clamp500(lsum);
        rsat     = clamp500(rsum);
        hold_eff = (hold == '0) ? 16'd200 : hold;
        gmin     = grip_min_deg;
        gmax     = grip_max_deg;
        unique case (req)
            dlgc_pkg::GR_MIN:   tgt_next = gmin;
            dlgc_pkg::GR_MAX:   tgt_next = gmax;
            dlgc_pkg::GR_ANGLE: tgt_next = (arg < gmin) ? gmin : ((arg > gmax) ? gmax : arg);
            default:            tgt_next = gtarget_reg;
        endcase
    end

    // divider operand selection
    logic [31:0]        lmag;
    logic [44:0]        gnum;
    logic [44:0]        gmag;
    always_comb begin
        lmag = lcount_reg[31] ? 32'(-lcount_reg) : 32'(lcount_reg);
        gnum = {gdelta_reg, 12'b0};
        gmag = gnum[44] ? 45'(-gnum) : gnum;
        div_start = cmd.start_lift | cmd.start_grip;
        if (cmd.start_grip) begin
            div_dividend = 48'(gmag);
            div_divisor  = grip_counts_per_deg_q12;
        end else begin
            div_dividend = 48'(lmag);
            div_divisor  = lift_counts_per_mm;
        end
    end

    dlgc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign sts.div_done = div_done;

    logic signed [48:0] qs;
    always_comb begin
        qs = $signed({1'b0, div_quot});
        if (cmd.take_lift && lcount_reg[31]) begin
            qs = -qs;
        end else if (cmd.take_grip && gnum[44]) begin
            qs = -qs;
        end
    end

    // loop outputs
    logic signed [17:0] lerr_u, gerr_u;
    logic signed [39:0] lerr_full, gerr_full;
    logic [10:0]        lift_p, grip_p;
    logic               lscale0, gscale0;
    always_comb begin
        lscale0   = (lift_counts_per_mm == '0);
        gscale0   = (grip_counts_per_deg_q12 == '0);
        lerr_full = vel_mode_reg ? 40'(lift_speed_reg)
                  : (40'(lift_target_reg) - 40'(lift_h_reg)) * 40'sd3;
        gerr_full = (40'(gtarget_reg) - 40'(grip_deg_reg)) * 40'sd6;
        lerr_u    = dlgc_pkg::sat_err(lerr_full);
        gerr_u    = dlgc_pkg::sat_err(gerr_full);
        lift_p    = lscale0 ? dlgc_pkg::PULSE_NEUTRAL : dlgc_pkg::loop_pulse(lerr_u);
        grip_p    = gscale0 ? dlgc_pkg::PULSE_NEUTRAL : dlgc_pkg::loop_pulse(gerr_u);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            lift_target_reg <= lift_target;
            lift_speed_reg  <= lift_speed;
            vel_mode_reg    <= vel_mode;
            lcount_reg      <= lcount;
            gdelta_reg      <= 33'(gcount) - 33'($signed(grip_zero_count));
            vx_reg          <= vx;
            w_reg           <= w;
            left_reg        <= dlgc_pkg::PULSE_NEUTRAL;
            right_reg       <= dlgc_pkg::PULSE_NEUTRAL;
            if (brake) begin
                dstate_reg <= dlgc_pkg::DS_BRAKED;
            end else if (since > 32'(hold_eff)) begin
                dstate_reg <= dlgc_pkg::DS_IDLE;
            end else begin
                dstate_reg <= dlgc_pkg::DS_DRIVING;
            end
        end
        if (cmd.start_lift) begin
            prod_reg <= 34'(w_reg) * $signed({18'b0, track});
        end
        if (cmd.take_lift) begin
            lift_h_reg <= dlgc_pkg::sat16(qs);
            rot_reg    <= rot;
        end
        if (cmd.take_grip) begin
            grip_deg_reg <= dlgc_pkg::sat16(qs);
            if (dstate_reg == dlgc_pkg::DS_DRIVING) begin
                left_reg  <= spd_pulse(lsat);
                right_reg <= spd_pulse(rsat);
            end
        end
        if (cmd.finish) begin
            out_reg <= {gscale0, lscale0, dstate_reg, grip_p, lift_p,
                        right_reg, left_reg};
        end
        if (!aresetn) begin
            gtarget_reg <= '0;
        end else if (cmd.load_in) begin
            gtarget_reg <= tgt_next;
        end
    end

    assign out_data = out_reg;

endmodule
`default_nettype wire

>>> rtl/dlgc_ctrl.sv
`default_nettype none
module dlgc_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    input  wire dlgc_pkg::dlgc_sts_t sts,
    output dlgc_pkg::dlgc_cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_LDIV, ST_LWAIT, ST_GWAIT, ST_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;

    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg;
        cmd         = '0;
        if (m_tready) begin
            mvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_LDIV;
                end
            end
            ST_LDIV: begin
                cmd.start_lift = 1'b1;
                state_next     = ST_LWAIT;
            end
            ST_LWAIT: begin
                if (sts.div_done) begin
                    cmd.take_lift  = 1'b1;
                    cmd.start_grip = 1'b1;
                    state_next     = ST_GWAIT;
                end
            end
            ST_GWAIT: begin
                if (sts.div_done) begin
                    cmd.take_grip = 1'b1;
                    state_next    = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.finish  = 1'b1;
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    a_fin_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!mvalid_reg || m_tready)) else $error("result overwritten");
    a_one_start: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.start_lift && cmd.start_grip)) else $error("double start");
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_in |=> state_reg == ST_LDIV) else $error("bad load");
    a_valid_after_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> mvalid_reg) else $error("valid missing");

endmodule
`default_nettype wire

>>> sim/drive_lift_grip_control_tick_top_tb.sv
module drive_lift_grip_control_tick_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [15:0] fwd;
        logic signed [15:0] turn;
        logic [15:0]        hold;
        logic [31:0]        since;
        logic               brake;
        logic signed [15:0] lift_tgt;
        logic signed [15:0] lift_spd;
        logic               vel_mode;
        logic [1:0]         req;
        logic signed [15:0] angle;
        logic signed [31:0] lift_cnt;
        logic signed [31:0] grip_cnt;
    } tick_t;

    typedef struct packed {
        logic [10:0] left;
        logic [10:0] right;
        logic [10:0] lift;
        logic [10:0] grip;
        logic [1:0]  dstate;
        logic        lift_err;
        logic        grip_err;
    } servo_out_t;

    typedef struct packed {
        tick_t      tick;
        logic       typed;
        servo_out_t res;
    } dir_row_t;

    localparam int PHASES     = 5;
    localparam int PER_PHASE  = 400;
    localparam int DOG_LIMIT  = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [191:0] s_tdata = '0;
    logic [3:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    logic [15:0]        track_w, lift_scale, grip_scale;
    logic signed [15:0] grip_zero, grip_min, grip_max, grip_target;

    servo_out_t pending_results[$];
    dir_row_t   dir_rows[$];
    int  errors = 0;
    int  dog = 0;
    bit  rx_free = 1'b0;

    drive_lift_grip_control_tick_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic [10:0] wheel_pulse(longint mmps);
        return 11'(clampl(1500 + (mmps * 300) / 400, 1000, 2000));
    endfunction

    function automatic logic [10:0] servo_pulse(longint err, longint gain);
        return 11'(clampl(1500 + clampl(err * gain, -300, 300), 1000, 2000));
    endfunction

    function automatic servo_out_t control_tick(tick_t t);
        servo_out_t r;
        longint gmin, gmax, a, hold, track, rot, h, deg;
        gmin = grip_min;
        gmax = grip_max;
        r = '{left: dlgc_pkg::PULSE_NEUTRAL, right: dlgc_pkg::PULSE_NEUTRAL,
              lift: dlgc_pkg::PULSE_NEUTRAL, grip: dlgc_pkg::PULSE_NEUTRAL,
              dstate: dlgc_pkg::DS_DRIVING, lift_err: 1'b0, grip_err: 1'b0};
        case (t.req)
            dlgc_pkg::GR_MIN: grip_target = 16'(gmin);
            dlgc_pkg::GR_MAX: grip_target = 16'(gmax);
            dlgc_pkg::GR_ANGLE: begin
                a = t.angle;
                grip_target = 16'(a < gmin ? gmin : (a > gmax ? gmax : a));
            end
            default: ;
        endcase
        hold = (t.hold == 0) ? 200 : longint'(t.hold);
        if (t.brake) begin
            r.dstate = dlgc_pkg::DS_BRAKED;
        end else if (longint'(t.since) > hold) begin
            r.dstate = dlgc_pkg::DS_IDLE;
        end else begin
            track = (track_w == 0) ? 600 : longint'(track_w);
            rot = (longint'(t.turn) * track) / 2000;
            r.left  = wheel_pulse(clampl(longint'(t.fwd) - rot, -500, 500));
            r.right = wheel_pulse(clampl(longint'(t.fwd) + rot, -500, 500));
        end
        if (lift_scale == 0) begin
            r.lift_err = 1'b1;
        end else if (t.vel_mode) begin
            r.lift = servo_pulse(t.lift_spd, 1);
        end else begin
            h = clampl(longint'(t.lift_cnt) / longint'(lift_scale), -32768, 32767);
            r.lift = servo_pulse(longint'(t.lift_tgt) - h, 3);
        end
        if (grip_scale == 0) begin
            r.grip_err = 1'b1;
        end else begin
            deg = clampl(((longint'(t.grip_cnt) - longint'(grip_zero)) * 4096)
                         / longint'(grip_scale), -32768, 32767);
            r.grip = servo_pulse(longint'(grip_target) - deg, 6);
        end
        return r;
    endfunction

    function automatic logic [191:0] pack_tick(tick_t t);
        return {t.grip_cnt, t.lift_cnt, t.angle, t.lift_spd, t.lift_tgt, t.since,
                t.hold, t.turn, t.fwd};
    endfunction

    function automatic logic [3:0] pack_flags(tick_t t);
        return {t.req, t.vel_mode, t.brake};
    endfunction

    function automatic servo_out_t unpack_result(logic [47:0] d);
        servo_out_t r;
        r.left = d[10:0];
        r.right = d[21:11];
        r.lift = d[32:22];
        r.grip = d[43:33];
        r.dstate = d[45:44];
        r.lift_err = d[46];
        r.grip_err = d[47];
        return r;
    endfunction

    function automatic logic [15:0] any16();
        return ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 1) ? 16'h7fff : 16'h8000)
                                           : 16'($urandom);
    endfunction

    function automatic tick_t random_tick();
        tick_t t;
        t.fwd  = $urandom_range(0, 3) == 0 ? any16() : 16'(int'($urandom_range(0, 1600)) - 800);
        t.turn = $urandom_range(0, 3) == 0 ? any16() : 16'(int'($urandom_range(0, 4000)) - 2000);
        t.hold = $urandom_range(0, 4) == 0 ? 16'd0 : 16'($urandom_range(0, 500));
        if ($urandom_range(0, 5) == 0) t.hold = 16'($urandom);
        t.since = $urandom_range(0, 5) == 0 ? $urandom : 32'($urandom_range(0, 520));
        t.brake = $urandom_range(0, 7) == 0;
        t.lift_tgt = $urandom_range(0, 3) == 0 ? any16() : 16'(int'($urandom_range(0, 400)) - 200);
        t.lift_spd = $urandom_range(0, 2) == 0 ? any16() : 16'(int'($urandom_range(0, 800)) - 400);
        t.vel_mode = 1'($urandom_range(0, 1));
        t.req = 2'($urandom_range(0, 3));
        t.angle = $urandom_range(0, 2) == 0 ? any16() : 16'(int'($urandom_range(0, 200)) - 100);
        t.lift_cnt = $urandom_range(0, 3) == 0 ? $urandom : 32'(int'($urandom_range(0, 4000)) - 2000);
        t.grip_cnt = $urandom_range(0, 3) == 0 ? $urandom
                                               : 32'(int'($urandom_range(0, 2000)) - 1000);
        return t;
    endfunction

    function automatic tick_t mk_tick(int fwd, int turn, int hold, logic [31:0] since,
                                      bit brake, int ltgt, int lspd, bit vmode,
                                      logic [1:0] req, int angle, int lcnt, int gcnt);
        return '{fwd: 16'(fwd), turn: 16'(turn), hold: 16'(hold), since: since,
                 brake: brake, lift_tgt: 16'(ltgt), lift_spd: 16'(lspd), vel_mode: vmode,
                 req: req, angle: 16'(angle), lift_cnt: 32'(lcnt), grip_cnt: 32'(gcnt)};
    endfunction

    function automatic servo_out_t mk_res(int l, int r, int li, int g, logic [1:0] ds);
        return '{left: 11'(l), right: 11'(r), lift: 11'(li), grip: 11'(g),
                 dstate: ds, lift_err: 1'b0, grip_err: 1'b0};
    endfunction

    task automatic add_row(tick_t t, bit typed, servo_out_t r);
        dir_rows.push_back('{tick: t, typed: typed, res: r});
    endtask

    task automatic write_regs(logic [15:0] tw, logic [15:0] ls, logic [15:0] gz,
                              logic [15:0] gs, logic [15:0] gmn, logic [15:0] gmx);
        logic [15:0] vals [0:6];
        vals = '{tw, ls, gz, gs, gmn, gmx, 16'hdead};
        for (int i = 0; i < 7; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= vals[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        track_w = tw;
        lift_scale = ls;
        grip_zero = gz;
        grip_scale = gs;
        grip_min = gmn;
        grip_max = gmx;
    endtask

    task automatic send_tick(tick_t t, bit typed, servo_out_t typed_res);
        servo_out_t r;
        int gap;
        gap = $urandom_range(0, 3) != 0 ? 0 :
              ($urandom_range(0, 9) == 0 ? $urandom_range(50, 300) : $urandom_range(1, 6));
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pack_tick(t);
        s_tuser <= pack_flags(t);
        do @(posedge aclk); while (!s_tready);
        r = control_tick(t);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    // result side: check and randomize backpressure
    initial begin
        servo_out_t got, want;
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got = unpack_result(m_tdata);
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.left !== want.left)
                        $display("%0t: left exp %0d got %0d", $time, want.left, got.left);
                    if (got.right !== want.right)
                        $display("%0t: right exp %0d got %0d", $time, want.right, got.right);
                    if (got.lift !== want.lift)
                        $display("%0t: lift exp %0d got %0d", $time, want.lift, got.lift);
                    if (got.grip !== want.grip)
                        $display("%0t: grip exp %0d got %0d", $time, want.grip, got.grip);
                    if (got.dstate !== want.dstate)
                        $display("%0t: state exp %0d got %0d", $time, want.dstate, got.dstate);
                    if (got.lift_err !== want.lift_err)
                        $display("%0t: lift_err exp %0b got %0b", $time, want.lift_err,
                                 got.lift_err);
                    if (got.grip_err !== want.grip_err)
                        $display("%0t: grip_err exp %0b got %0b", $time, want.grip_err,
                                 got.grip_err);
                    if (got !== want) errors++;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (rx_free) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= $urandom_range(0, 2) != 0;
                hold_left = $urandom_range(0, 9) == 0 ? $urandom_range(20, 300)
                                                      : $urandom_range(0, 8);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            dog <= 0;
        end else if (dog >= DOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            dog <= dog + 1;
        end
    end

    initial begin
        servo_out_t none;
        none = '0;
        grip_target = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_regs(16'd600, 16'd5, 16'd0, 16'd4096, 16'd0, 16'd90);

        add_row(mk_tick(0, 0, 0, 0, 1, 0, 0, 0, dlgc_pkg::GR_MIN, 0, 0, 0), 1,
                mk_res(1500, 1500, 1500, 1500, dlgc_pkg::DS_BRAKED));
        add_row(mk_tick(300, 0, 0, 201, 0, 0, 0, 0, dlgc_pkg::GR_MIN, 0, 0, 0), 1,
                mk_res(1500, 1500, 1500, 1500, dlgc_pkg::DS_IDLE));
        add_row(mk_tick(0, 0, 0, 200, 0, 0, 0, 0, dlgc_pkg::GR_MIN, 0, 0, 0), 1,
                mk_res(1500, 1500, 1500, 1500, dlgc_pkg::DS_DRIVING));
        add_row(mk_tick(32767, 0, 65535, 0, 0, 32767, 0, 0, dlgc_pkg::GR_MIN, 0, 0, 0), 1,
                mk_res(1875, 1875, 1800, 1500, dlgc_pkg::DS_DRIVING));
        add_row(mk_tick(-32768, 0, 65535, 0, 0, -32768, 0, 0, dlgc_pkg::GR_MIN, 0, 0, 0), 1,
                mk_res(1125, 1125, 1200, 1500, dlgc_pkg::DS_DRIVING));
        add_row(mk_tick(0, 32767, 1, 1, 0, 0, 0, 0, dlgc_pkg::GR_MIN, 0, 0, 0), 0, none);
        add_row(mk_tick(0, -32768, 1, 0, 0, 0, 0, 0, dlgc_pkg::GR_MIN, 0, 0, 0), 0, none);
        add_row(mk_tick(0, 0, 65535, 32'hffffffff, 0, 0, 0, 0, dlgc_pkg::GR_MIN, 0, 0, 0), 1,
                mk_res(1500, 1500, 1500, 1500, dlgc_pkg::DS_IDLE));
        add_row(mk_tick(0, 0, 0, 0, 0, 0, 32767, 1, dlgc_pkg::GR_MAX, 0, 0, 0), 1,
                mk_res(1500, 1500, 1800, 1800, dlgc_pkg::DS_DRIVING));
        add_row(mk_tick(0, 0, 0, 0, 0, 0, -32768, 1, dlgc_pkg::GR_KEEP, 0, 0, 0), 1,
                mk_res(1500, 1500, 1200, 1800, dlgc_pkg::DS_DRIVING));
        add_row(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, dlgc_pkg::GR_ANGLE, -32768, 0, 0), 1,
                mk_res(1500, 1500, 1500, 1500, dlgc_pkg::DS_DRIVING));
        add_row(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, dlgc_pkg::GR_ANGLE, 32767, 0, 32'h7fffffff), 1,
                mk_res(1500, 1500, 1500, 1200, dlgc_pkg::DS_DRIVING));
        add_row(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, dlgc_pkg::GR_KEEP, 0, 32'h80000000,
                        32'h80000000), 1,
                mk_res(1500, 1500, 1800, 1800, dlgc_pkg::DS_DRIVING));
        add_row(mk_tick(450, 900, 100, 50, 0, 20, 0, 0, dlgc_pkg::GR_ANGLE, 45, 77, 1000), 0,
                none);
        add_row(mk_tick(-120, -700, 300, 300, 0, -5, 33, 0, dlgc_pkg::GR_KEEP, 12, -93, -4097),
                0, none);
        add_row(mk_tick(-1, 1, 0, 199, 1, 1, -1, 1, dlgc_pkg::GR_MAX, -1, -1, -1), 0, none);

        foreach (dir_rows[i]) send_tick(dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].res);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: write_regs(16'd0, 16'd0, 16'h8000, 16'd0, 16'h8000, 16'h7fff);
                1: write_regs(16'hffff, 16'd1, 16'h7fff, 16'd1, 16'h7fff, 16'h8000);
                2: write_regs(16'd1, 16'hffff, 16'd0, 16'hffff, -16'sd45, 16'sd45);
                3: write_regs(16'd600, 16'd5, 16'd100, 16'd12288, 16'd0, 16'd90);
                default: write_regs(16'd350, 16'd3, -16'sd200, 16'd2048, -16'sd30, 16'd60);
            endcase
            rx_free = (p == 1);
            for (int n = 0; n < PER_PHASE; n++) send_tick(random_tick(), 0, none);
            drain();
        end

        if (errors == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

>>> drive_lift_grip_control_tick_top.f
rtl/dlgc_pkg.sv
rtl/dlgc_div.sv
rtl/dlgc_datapath.sv
rtl/dlgc_ctrl.sv
rtl/drive_lift_grip_control_tick_top.sv
sim/drive_lift_grip_control_tick_top_tb.sv
